// ===== design/svna_pkg.sv =====
// shared types and constants for the smooth vertex normal accumulator
package svna_pkg;

    localparam int VERTEX_SLOTS = 1024;
    localparam int SLOT_W       = $clog2(VERTEX_SLOTS);
    localparam int IDX_W        = 10;
    localparam int POS_W        = 32;
    localparam int SUM_W        = 20;
    localparam int NORM_W       = 16;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic                    start_mesh;
        logic [IDX_W-1:0]        vtx_slot;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [NORM_W-1:0] norm_x;
        logic signed [NORM_W-1:0] norm_y;
        logic signed [NORM_W-1:0] norm_z;
        logic                     present;
        logic                     degenerate;
    } t_out;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum_x;
        logic signed [SUM_W-1:0] sum_y;
        logic signed [SUM_W-1:0] sum_z;
    } t_word;

endpackage

// ===== design/smooth_vertex_normal_accumulator.sv =====
// top level: per-vertex face normal accumulation with an iterative normalizer
//
//  channel   direction  handshake             payload
//  command   in         start / busy          i_item (t_in)
//  result    out        o_res_valid strobe    o_result (t_out)
//
// a corner that does not close a face is only stored; a closing corner and a
// read run the 32-step square root, the three 15-step divisions and the
// bit-wise range scaling, the cross products and squares sharing one
// multiplier; a face ends with 3 read-modify-write passes.
// after reset, and on every item with start_mesh set, a clearing pass over all
// VERTEX_SLOTS table words runs before the item is handled.
// a result beat is shown for one cycle and cannot be stalled.
module smooth_vertex_normal_accumulator
    import svna_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_res_valid,
    output t_out o_result
);

    localparam int DM_W  = 33;
    localparam int MAG_W = 30;
    localparam int MUL_W = MAG_W + 1;
    localparam int NM_W  = 62;
    localparam int W64   = 64;
    localparam int DIV_W = 47;
    localparam int Q_W   = 15;

    typedef enum logic [18:0] {
        S_CLEAR  = 19'b1 << 0,
        S_IDLE   = 19'b1 << 1,
        S_DECODE = 19'b1 << 2,
        S_DIFF   = 19'b1 << 3,
        S_FSCALE = 19'b1 << 4,
        S_XMUL   = 19'b1 << 5,
        S_XACC   = 19'b1 << 6,
        S_NLOAD  = 19'b1 << 7,
        S_NSCALE = 19'b1 << 8,
        S_SQMUL  = 19'b1 << 9,
        S_SQACC  = 19'b1 << 10,
        S_SQRT   = 19'b1 << 11,
        S_DIVLD  = 19'b1 << 12,
        S_DIV    = 19'b1 << 13,
        S_FINISH = 19'b1 << 14,
        S_UPD_RD = 19'b1 << 15,
        S_UPD_WB = 19'b1 << 16,
        S_RD_CHK = 19'b1 << 17,
        S_OUT    = 19'b1 << 18
    } t_state;

    function automatic logic signed [MUL_W-1:0] to_signed(
        input logic [MAG_W-1:0] m,
        input logic             neg
    );
        logic signed [MUL_W-1:0] v;
        v = $signed({1'b0, m});
        return neg ? -v : v;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0]  a,
        input logic signed [NORM_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W+1-NORM_W){b[NORM_W-1]}}, b});
        if (s > $signed({1'b0, SUM_MAX})) begin
            return SUM_MAX;
        end else if (s < $signed({1'b1, SUM_MIN})) begin
            return SUM_MIN;
        end
        return s[SUM_W-1:0];
    endfunction

    function automatic logic signed [SUM_W-1:0] q_to_sum(input logic signed [NORM_W-1:0] q);
        return $signed({{(SUM_W-NORM_W){q[NORM_W-1]}}, q});
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    // state
    t_state                   r_state, n_state;
    logic [SLOT_W-1:0]        r_clr, n_clr;
    logic                     r_resume, n_resume;
    logic [1:0]               r_cnt, n_cnt;
    t_in                      r_item, n_item;
    logic signed [POS_W-1:0]  r_held [6];
    logic signed [POS_W-1:0]  n_held [6];
    logic [SLOT_W-1:0]        r_hidx [2];
    logic [SLOT_W-1:0]        n_hidx [2];
    logic [DM_W-1:0]          r_dm [6];
    logic [DM_W-1:0]          n_dm [6];
    logic                     r_ds [6];
    logic                     n_ds [6];
    logic [2:0]               r_step, n_step;
    logic [W64-1:0]           r_prod, n_prod;
    logic signed [W64-1:0]    r_c [3];
    logic signed [W64-1:0]    n_c [3];
    logic [NM_W-1:0]          r_nm [3];
    logic [NM_W-1:0]          n_nm [3];
    logic                     r_ns [3];
    logic                     n_ns [3];
    logic [W64-1:0]           r_sum, n_sum;
    logic [W64-1:0]           r_sv, n_sv;
    logic [W64-1:0]           r_sr, n_sr;
    logic [W64-1:0]           r_bit, n_bit;
    logic [31:0]              r_mag, n_mag;
    logic [DIV_W-1:0]         r_rem, n_rem;
    logic [DIV_W-1:0]         r_dvs, n_dvs;
    logic [Q_W-1:0]           r_q, n_q;
    logic [3:0]               r_b, n_b;
    logic [1:0]               r_comp, n_comp;
    logic signed [NORM_W-1:0] r_q3 [3];
    logic signed [NORM_W-1:0] n_q3 [3];
    logic                     r_deg, n_deg;
    logic [1:0]               r_k, n_k;
    t_out                     r_out, n_out;

    // table
    t_word             mem [VERTEX_SLOTS];
    t_word             r_rdata;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_raddr;
    t_word             mem_wdata;

    // shared multiplier
    logic signed [MUL_W-1:0]   w_ma, w_mb;
    logic signed [2*MUL_W-1:0] w_mp;
    logic signed [MUL_W-1:0]   w_dsv [6];

    logic [SLOT_W-1:0]       w_slot;
    logic [SLOT_W-1:0]       w_upd_slot;
    logic signed [POS_W-1:0] w_pos [3];
    logic                    w_fbig, w_nbig;

    assign w_slot   = slot_of(r_item.vtx_slot);
    assign w_pos[0] = r_item.pos_x;
    assign w_pos[1] = r_item.pos_y;
    assign w_pos[2] = r_item.pos_z;

    always_comb begin
        w_fbig = 1'b0;
        for (int i = 0; i < 6; i++) begin
            w_dsv[i] = to_signed(r_dm[i][MAG_W-1:0], r_ds[i]);
            w_fbig   = w_fbig | (|r_dm[i][DM_W-1:MAG_W]);
        end
        w_nbig = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_nbig = w_nbig | (|r_nm[i][NM_W-1:MAG_W]);
        end
    end

    always_comb begin
        case (r_k)
            2'd0:    w_upd_slot = r_hidx[0];
            2'd1:    w_upd_slot = r_hidx[1];
            default: w_upd_slot = w_slot;
        endcase
    end

    // operand select: cross terms in XMUL, squares in SQMUL
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_XMUL) begin
            case (r_step)
                3'd0:    begin w_ma = w_dsv[4]; w_mb = w_dsv[2]; end
                3'd1:    begin w_ma = w_dsv[5]; w_mb = w_dsv[1]; end
                3'd2:    begin w_ma = w_dsv[5]; w_mb = w_dsv[0]; end
                3'd3:    begin w_ma = w_dsv[3]; w_mb = w_dsv[2]; end
                3'd4:    begin w_ma = w_dsv[3]; w_mb = w_dsv[1]; end
                default: begin w_ma = w_dsv[4]; w_mb = w_dsv[0]; end
            endcase
        end else if (r_state == S_SQMUL) begin
            w_ma = to_signed(r_nm[r_step[1:0]][MAG_W-1:0], 1'b0);
            w_mb = w_ma;
        end
    end

    assign w_mp = w_ma * w_mb;

    always_comb begin
        logic signed [DM_W-1:0] d;
        logic [W64-1:0]         a64;
        logic [W64-1:0]         t;
        logic [SUM_W-1:0]       a20;
        logic                   qb;
        logic signed [NORM_W-1:0] qs;
        logic [1:0]             ci;
        t_word                  w;

        d   = '0;
        a64 = '0;
        t   = '0;
        a20 = '0;
        qb  = 1'b0;
        qs  = '0;
        ci  = r_step[2:1];
        w   = r_rdata;

        n_state  = r_state;
        n_clr    = r_clr;
        n_resume = r_resume;
        n_cnt    = r_cnt;
        n_item   = r_item;
        n_held   = r_held;
        n_hidx   = r_hidx;
        n_dm     = r_dm;
        n_ds     = r_ds;
        n_step   = r_step;
        n_prod   = r_prod;
        n_c      = r_c;
        n_nm     = r_nm;
        n_ns     = r_ns;
        n_sum    = r_sum;
        n_sv     = r_sv;
        n_sr     = r_sr;
        n_bit    = r_bit;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_dvs    = r_dvs;
        n_q      = r_q;
        n_b      = r_b;
        n_comp   = r_comp;
        n_q3     = r_q3;
        n_deg    = r_deg;
        n_k      = r_k;
        n_out    = r_out;

        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_raddr = w_slot;

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_clr  = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state  = r_resume ? S_DECODE : S_IDLE;
                    n_resume = 1'b0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.start_mesh) begin
                        n_cnt    = '0;
                        n_resume = 1'b1;
                        n_state  = S_CLEAR;
                    end else begin
                        n_state = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                if (r_item.kind == KIND_READ) begin
                    n_state = S_RD_CHK;
                end else if (r_cnt != 2'd2) begin
                    if (r_cnt[0]) begin
                        n_held[3] = w_pos[0];
                        n_held[4] = w_pos[1];
                        n_held[5] = w_pos[2];
                        n_hidx[1] = w_slot;
                    end else begin
                        n_held[0] = w_pos[0];
                        n_held[1] = w_pos[1];
                        n_held[2] = w_pos[2];
                        n_hidx[0] = w_slot;
                    end
                    n_cnt   = r_cnt + 2'd1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt   = '0;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    d = $signed({r_held[3+i][POS_W-1], r_held[3+i]})
                        - $signed({r_held[i][POS_W-1], r_held[i]});
                    n_dm[i] = d[DM_W-1] ? unsigned'(-d) : unsigned'(d);
                    n_ds[i] = d[DM_W-1];
                    d = $signed({w_pos[i][POS_W-1], w_pos[i]})
                        - $signed({r_held[i][POS_W-1], r_held[i]});
                    n_dm[3+i] = d[DM_W-1] ? unsigned'(-d) : unsigned'(d);
                    n_ds[3+i] = d[DM_W-1];
                end
                n_state = S_FSCALE;
            end
            S_FSCALE: begin
                if (w_fbig) begin
                    for (int i = 0; i < 6; i++) begin
                        n_dm[i] = r_dm[i] >> 1;
                    end
                end else begin
                    n_step = '0;
                    for (int i = 0; i < 3; i++) begin
                        n_c[i] = '0;
                    end
                    n_state = S_XMUL;
                end
            end
            S_XMUL: begin
                n_prod  = {{(W64-2*MUL_W){w_mp[2*MUL_W-1]}}, w_mp};
                n_state = S_XACC;
            end
            S_XACC: begin
                // even steps add the first term, odd steps subtract the second
                n_c[ci] = r_step[0] ? r_c[ci] - $signed(r_prod) : r_c[ci] + $signed(r_prod);
                if (r_step == 3'd5) begin
                    n_state = S_NLOAD;
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = S_XMUL;
                end
            end
            S_NLOAD: begin
                for (int i = 0; i < 3; i++) begin
                    a64     = r_c[i][W64-1] ? unsigned'(-r_c[i]) : unsigned'(r_c[i]);
                    n_nm[i] = a64[NM_W-1:0];
                    n_ns[i] = r_c[i][W64-1];
                end
                n_state = S_NSCALE;
            end
            S_NSCALE: begin
                if (w_nbig) begin
                    for (int i = 0; i < 3; i++) begin
                        n_nm[i] = r_nm[i] >> 1;
                    end
                end else begin
                    n_step  = '0;
                    n_sum   = '0;
                    n_state = S_SQMUL;
                end
            end
            S_SQMUL: begin
                n_prod  = {{(W64-2*MUL_W){w_mp[2*MUL_W-1]}}, w_mp};
                n_state = S_SQACC;
            end
            S_SQACC: begin
                n_sum = r_sum + r_prod;
                if (r_step == 3'd2) begin
                    if (n_sum == '0) begin
                        n_deg = 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            n_q3[i] = '0;
                        end
                        n_state = S_FINISH;
                    end else begin
                        n_deg   = 1'b0;
                        n_sv    = n_sum;
                        n_sr    = '0;
                        n_bit   = 64'd1 << 62;
                        n_state = S_SQRT;
                    end
                end else begin
                    n_step  = r_step + 3'd1;
                    n_state = S_SQMUL;
                end
            end
            S_SQRT: begin
                t = r_sr + r_bit;
                if (r_sv >= t) begin
                    n_sv = r_sv - t;
                    n_sr = (r_sr >> 1) + r_bit;
                end else begin
                    n_sr = r_sr >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == 64'd1) begin
                    n_mag   = n_sr[31:0];
                    n_comp  = '0;
                    n_state = S_DIVLD;
                end
            end
            S_DIVLD: begin
                // numerator |c| * 2^14 + mag / 2
                n_rem   = {3'b0, r_nm[r_comp][MAG_W-1:0], 14'b0} + {16'b0, r_mag[31:1]};
                n_dvs   = {1'b0, r_mag, 14'b0};
                n_q     = '0;
                n_b     = 4'd14;
                n_state = S_DIV;
            end
            S_DIV: begin
                qb = (r_rem >= r_dvs);
                if (qb) begin
                    n_rem = r_rem - r_dvs;
                end
                n_q   = {r_q[Q_W-2:0], qb};
                n_dvs = r_dvs >> 1;
                n_b   = r_b - 4'd1;
                if (r_b == 4'd0) begin
                    qs           = $signed({1'b0, n_q});
                    n_q3[r_comp] = r_ns[r_comp] ? -qs : qs;
                    if (r_comp == 2'd2) begin
                        n_state = S_FINISH;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = S_DIVLD;
                    end
                end
            end
            S_FINISH: begin
                if (r_item.kind == KIND_READ) begin
                    n_out.norm_x     = r_q3[0];
                    n_out.norm_y     = r_q3[1];
                    n_out.norm_z     = r_q3[2];
                    n_out.present    = 1'b1;
                    n_out.degenerate = r_deg;
                    n_state          = S_OUT;
                end else begin
                    n_k     = '0;
                    n_state = S_UPD_RD;
                end
            end
            S_UPD_RD: begin
                mem_raddr = w_upd_slot;
                n_state   = S_UPD_WB;
            end
            S_UPD_WB: begin
                mem_we          = 1'b1;
                mem_waddr       = w_upd_slot;
                mem_wdata.valid = 1'b1;
                mem_wdata.sum_x = w.valid ? sat_add(w.sum_x, r_q3[0]) : q_to_sum(r_q3[0]);
                mem_wdata.sum_y = w.valid ? sat_add(w.sum_y, r_q3[1]) : q_to_sum(r_q3[1]);
                mem_wdata.sum_z = w.valid ? sat_add(w.sum_z, r_q3[2]) : q_to_sum(r_q3[2]);
                if (r_k == 2'd2) begin
                    n_state = S_IDLE;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = S_UPD_RD;
                end
            end
            S_RD_CHK: begin
                if (!w.valid) begin
                    n_out   = '0;
                    n_state = S_OUT;
                end else begin
                    a20     = w.sum_x[SUM_W-1] ? unsigned'(-w.sum_x) : unsigned'(w.sum_x);
                    n_nm[0] = {{(NM_W-SUM_W){1'b0}}, a20};
                    n_ns[0] = w.sum_x[SUM_W-1];
                    a20     = w.sum_y[SUM_W-1] ? unsigned'(-w.sum_y) : unsigned'(w.sum_y);
                    n_nm[1] = {{(NM_W-SUM_W){1'b0}}, a20};
                    n_ns[1] = w.sum_y[SUM_W-1];
                    a20     = w.sum_z[SUM_W-1] ? unsigned'(-w.sum_z) : unsigned'(w.sum_z);
                    n_nm[2] = {{(NM_W-SUM_W){1'b0}}, a20};
                    n_ns[2] = w.sum_z[SUM_W-1];
                    n_state = S_NSCALE;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_resume <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_resume <= n_resume;
            r_cnt    <= n_cnt;
        end
        r_item <= n_item;
        r_held <= n_held;
        r_hidx <= n_hidx;
        r_dm   <= n_dm;
        r_ds   <= n_ds;
        r_step <= n_step;
        r_prod <= n_prod;
        r_c    <= n_c;
        r_nm   <= n_nm;
        r_ns   <= n_ns;
        r_sum  <= n_sum;
        r_sv   <= n_sv;
        r_sr   <= n_sr;
        r_bit  <= n_bit;
        r_mag  <= n_mag;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_q    <= n_q;
        r_b    <= n_b;
        r_comp <= n_comp;
        r_q3   <= n_q3;
        r_deg  <= n_deg;
        r_k    <= n_k;
        r_out  <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_result    = r_out;

`ifndef SYNTHESIS
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe held longer than one cycle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_result_read_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (r_item.kind == KIND_READ))
        else $error("result produced for a corner beat");

    a_corner_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("corner count out of range");
`endif

endmodule
